// ===== design/spc_pkg.sv =====
// Shared constants, types and helpers for the segmented path cursor.
package spc_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_BITS     = $clog2(MAX_SEGMENTS);
    localparam int DIST_BITS    = 32;
    localparam int REM_BITS     = DIST_BITS + 1;
    localparam int CNT_BITS     = 7;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_FWD    = 2'd1,
        CMD_BWD    = 2'd2,
        CMD_MOVETO = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_FWALK,
        ST_BWALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd                  cmd;
        logic [SEG_BITS-1:0]   load_slot;
        logic [DIST_BITS-1:0]  amount;
    } t_item;

    typedef struct packed {
        logic [SEG_BITS-1:0]   cursor_segment;
        logic [DIST_BITS-1:0]  cursor_offset;
        logic                  clamped;
    } t_result;

    // Index of the last segment in use; zero counts as one, large counts saturate
    function automatic logic [SEG_BITS-1:0] last_segment(input logic [CNT_BITS-1:0] cnt);
        logic [SEG_BITS-1:0] last;
        if (cnt == '0) begin
            last = '0;
        end else if (cnt >= CNT_BITS'(MAX_SEGMENTS)) begin
            last = SEG_BITS'(MAX_SEGMENTS - 1);
        end else begin
            last = SEG_BITS'(cnt - CNT_BITS'(1));
        end
        return last;
    endfunction

endpackage

// ===== design/spc_core.sv =====
// Length table, cursor registers and the segment walking sequencer.
module spc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  spc_pkg::t_item                i_item,
    input  logic [spc_pkg::SEG_BITS-1:0]  i_last_seg,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output spc_pkg::t_result              o_res
);
    import spc_pkg::*;

    // Length table: one write port, one registered read port
    logic [DIST_BITS-1:0] r_len_mem [MAX_SEGMENTS];
    logic [DIST_BITS-1:0] r_rdata;
    logic                 rd_en;
    logic [SEG_BITS-1:0]  rd_addr;
    logic                 wr_en;

    t_state               r_state, n_state;
    logic [SEG_BITS-1:0]  r_seg, n_seg;
    logic [DIST_BITS-1:0] r_off, n_off;
    logic [DIST_BITS-1:0] r_dist, n_dist;
    logic [REM_BITS-1:0]  r_rem, n_rem;
    logic                 r_clamp, n_clamp;

    logic [SEG_BITS-1:0]  seg_sat;
    logic                 bwd_fit;
    logic [REM_BITS-1:0]  fwd_sum;
    logic                 fwd_fit;
    logic                 walk_fit;
    logic                 at_last;
    logic                 at_first;
    logic                 take_item;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_len_mem[i_item.load_slot] <= i_item.amount;
        end
        if (rd_en) begin
            r_rdata <= r_len_mem[rd_addr];
        end
    end

    // Conditions shared by the sequencer and the datapath
    assign take_item = i_item_valid && (r_state == ST_IDLE);
    assign seg_sat   = (r_seg > i_last_seg) ? i_last_seg : r_seg;
    assign bwd_fit   = r_off >= i_item.amount;
    assign fwd_sum   = {1'b0, r_off} + {1'b0, r_dist};
    assign fwd_fit   = fwd_sum <= {1'b0, r_rdata};
    assign walk_fit  = {1'b0, r_rdata} >= r_rem;
    assign at_last   = r_seg == i_last_seg;
    assign at_first  = r_seg == '0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    unique case (i_item.cmd)
                        CMD_LOAD:              n_state = ST_DONE;
                        CMD_FWD, CMD_MOVETO:   n_state = ST_FIRST;
                        CMD_BWD: begin
                            if (bwd_fit || seg_sat == '0) n_state = ST_DONE;
                            else                          n_state = ST_BWALK;
                        end
                        default:               n_state = ST_DONE;
                    endcase
                end
            end
            ST_FIRST: begin
                if (fwd_fit || at_last) n_state = ST_DONE;
                else                    n_state = ST_FWALK;
            end
            ST_FWALK: begin
                if (walk_fit || at_last) n_state = ST_DONE;
            end
            ST_BWALK: begin
                if (walk_fit || at_first) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory control and handshake outputs
    always_comb begin
        n_seg   = r_seg;
        n_off   = r_off;
        n_dist  = r_dist;
        n_rem   = r_rem;
        n_clamp = r_clamp;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        o_item_ready = (r_state == ST_IDLE);
        o_res_valid  = (r_state == ST_DONE);
        unique case (r_state)
            ST_IDLE: begin
                if (take_item) begin
                    n_clamp = 1'b0;
                    unique case (i_item.cmd)
                        CMD_LOAD: wr_en = 1'b1;
                        CMD_FWD: begin
                            n_seg   = seg_sat;
                            n_dist  = i_item.amount;
                            rd_en   = 1'b1;
                            rd_addr = seg_sat;
                        end
                        CMD_MOVETO: begin
                            n_seg   = '0;
                            n_off   = '0;
                            n_dist  = i_item.amount;
                            rd_en   = 1'b1;
                            rd_addr = '0;
                        end
                        CMD_BWD: begin
                            n_seg = seg_sat;
                            if (bwd_fit) begin
                                n_off = r_off - i_item.amount;
                            end else if (seg_sat == '0) begin
                                n_off   = '0;
                                n_clamp = 1'b1;
                            end else begin
                                // step into the previous segment with the shortfall
                                n_rem   = {1'b0, i_item.amount - r_off};
                                n_seg   = seg_sat - SEG_BITS'(1);
                                rd_en   = 1'b1;
                                rd_addr = seg_sat - SEG_BITS'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIRST: begin
                if (fwd_fit) begin
                    n_off = fwd_sum[DIST_BITS-1:0];
                end else if (at_last) begin
                    n_off   = r_rdata;
                    n_clamp = 1'b1;
                end else begin
                    // excess carries into the next segment
                    n_rem   = fwd_sum - {1'b0, r_rdata};
                    n_seg   = r_seg + SEG_BITS'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_seg + SEG_BITS'(1);
                end
            end
            ST_FWALK: begin
                if (walk_fit) begin
                    n_off = r_rem[DIST_BITS-1:0];
                end else if (at_last) begin
                    n_off   = r_rdata;
                    n_clamp = 1'b1;
                end else begin
                    n_rem   = r_rem - {1'b0, r_rdata};
                    n_seg   = r_seg + SEG_BITS'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_seg + SEG_BITS'(1);
                end
            end
            ST_BWALK: begin
                if (walk_fit) begin
                    n_off = r_rdata - r_rem[DIST_BITS-1:0];
                end else if (at_first) begin
                    n_off   = '0;
                    n_clamp = 1'b1;
                end else begin
                    n_rem   = r_rem - {1'b0, r_rdata};
                    n_seg   = r_seg - SEG_BITS'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_seg - SEG_BITS'(1);
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // Control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seg   <= '0;
            r_off   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_off   <= n_off;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_dist  <= n_dist;
        r_rem   <= n_rem;
        r_clamp <= n_clamp;
    end

    assign o_res.cursor_segment = r_seg;
    assign o_res.cursor_offset  = r_off;
    assign o_res.clamped        = r_clamp;

endmodule

// ===== design/segmented_path_cursor_top.sv =====
// Segmented path cursor: a load, or a backward move that ends within its segment or clamps
// at segment 0, goes straight to the result; a backward move crossing boundaries walks back
// one segment per boundary, and a forward move or move-to reads its start segment and then walks forward.
// One item at a time, one length read per walked segment; the output register frees the
// core, so it can start the next item once its result has moved there, unless the output stalls.
// Reset (sync, active low): cursor at segment 0 offset 0, count 1; lengths undefined.
module segmented_path_cursor_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spc_pkg::CNT_BITS-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [spc_pkg::SEG_BITS-1:0]   i_load_slot,
    input  logic [spc_pkg::DIST_BITS-1:0]  i_amount,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [spc_pkg::SEG_BITS-1:0]   o_cursor_segment,
    output logic [spc_pkg::DIST_BITS-1:0]  o_cursor_offset,
    output logic                           o_clamped
);
    import spc_pkg::*;

    logic [CNT_BITS-1:0] r_segment_count;
    logic [SEG_BITS-1:0] last_seg;
    t_item               item;
    logic                res_valid;
    logic                res_take;
    t_result             res;
    logic                r_out_valid;
    t_result             r_out;

    // Segment count register; the user must write it only while the block is idle, the block itself does not enforce it
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_count <= CNT_BITS'(1);
        end else if (i_cfg_valid) begin
            r_segment_count <= i_cfg_data;
        end
    end

    assign last_seg       = last_segment(r_segment_count);
    assign item.cmd       = t_cmd'(i_cmd);
    assign item.load_slot = i_load_slot;
    assign item.amount    = i_amount;

    spc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .o_item_ready (o_in_ready),
        .i_item       (item),
        .i_last_seg   (last_seg),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    // Output register: loads a finished result when empty or being drained
    assign res_take = res_valid && (!r_out_valid || i_out_ready);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cursor_segment = r_out.cursor_segment;
    assign o_cursor_offset  = r_out.cursor_offset;
    assign o_clamped        = r_out.clamped;

endmodule
